@@ rtl/core/ets_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_pkg
// shared types and constants of the elapsed time statistics block
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int TICK_W = 32;
    localparam int WIN_W  = 16;
    localparam int ACC_W  = TICK_W + WIN_W;
    localparam int DIV_W  = WIN_W + 1;
    localparam int STEP_W = 4;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd16;
    localparam logic [TICK_W-1:0] ALL_ONES     = {TICK_W{1'b1}};

    // operands of one mean update: (mcand * mult + addend) / divisor
    typedef struct packed {
        logic [TICK_W-1:0] mcand;
        logic [TICK_W-1:0] addend;
        logic [WIN_W-1:0]  mult;
        logic [DIV_W-1:0]  divisor;
    } ets_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ets_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/ets_muldiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_muldiv
// serial multiply-add (one bit per cycle) then radix-4 divide (two quotient
// bits per cycle) for the running mean update
// ----------------------------------------------------------------------------
module ets_muldiv (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire ets_pkg::ets_req_t           req,
    output ets_pkg::ets_stat_t               stat,
    output logic [ets_pkg::TICK_W-1:0]       quotient
);
    import ets_pkg::*;

    localparam logic PH_MUL = 1'b0;
    localparam logic PH_DIV = 1'b1;

    logic [ACC_W-1:0]  acc_reg,  acc_next;
    logic [ACC_W-1:0]  mc_reg,   mc_next;
    logic [WIN_W-1:0]  mul_reg,  mul_next;
    logic [DIV_W-1:0]  div_reg,  div_next;
    logic [DIV_W-1:0]  rem_reg,  rem_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              phase_reg, phase_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ACC_W-1:0]   acc_mul;
    logic [DIV_W+1:0]   part_rem;
    logic [DIV_W+1:0]   d1, d2, d3;
    logic [DIV_W+1:0]   rem_sel;
    logic [1:0]         digit;

    assign d1 = {2'b00, div_reg};
    assign d2 = {1'b0, div_reg, 1'b0};
    assign d3 = d1 + d2;

    assign acc_mul  = acc_reg + (mul_reg[0] ? mc_reg : '0);
    assign part_rem = {rem_reg, acc_reg[TICK_W-1 -: 2]};

    always_comb begin
        if (part_rem >= d3) begin
            digit   = 2'd3;
            rem_sel = part_rem - d3;
        end else if (part_rem >= d2) begin
            digit   = 2'd2;
            rem_sel = part_rem - d2;
        end else if (part_rem >= d1) begin
            digit   = 2'd1;
            rem_sel = part_rem - d1;
        end else begin
            digit   = 2'd0;
            rem_sel = part_rem;
        end
    end

    always_comb begin
        acc_next   = acc_reg;
        mc_next    = mc_reg;
        mul_next   = mul_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start && !busy_reg) begin
            acc_next   = {{WIN_W{1'b0}}, req.addend};
            mc_next    = {{WIN_W{1'b0}}, req.mcand};
            mul_next   = req.mult;
            div_next   = req.divisor;
            cnt_next   = '0;
            phase_next = PH_MUL;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (phase_reg == PH_MUL) begin
                acc_next = acc_mul;
                mc_next  = {mc_reg[ACC_W-2:0], 1'b0};
                mul_next = {1'b0, mul_reg[WIN_W-1:1]};
                if (cnt_reg == '1) begin
                    // quotient fits 32 bits, so the top part is already below the divisor
                    rem_next   = {1'b0, acc_mul[ACC_W-1:TICK_W]};
                    phase_next = PH_DIV;
                end
            end else begin
                rem_next            = rem_sel[DIV_W-1:0];
                acc_next[TICK_W-1:0] = {acc_reg[TICK_W-3:0], digit};
                if (cnt_reg == '1) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_MUL;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mul_reg <= mul_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = acc_reg[TICK_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/elapsed_time_statistics.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elapsed_time_statistics
// latency monitor: count, mean, minimum, maximum and last elapsed ticks
// ----------------------------------------------------------------------------
// Each input transfer carries a command (clear, start, stop) and a 32-bit tick
// value; each one yields exactly one result transfer holding all statistics
// after the command. Stop measures (tick - start tick) mod 2^32 and updates
// the mean as (mean*(n-1)+elapsed)/n while n-1 is within the window, then as
// (mean*(W-1)+elapsed)/W. Clear, start and unused commands go from transfer
// straight to the result state; a stop first runs the serial unit:
// one-bit multiply-add, then radix-4 division, then hand-off to the mean
// register. One command is in work at a time; the next input transfer is taken
// as soon as the result sits in the output register, even while that result
// still waits for m_ready. The user writes window_size (cfg_we/cfg_wdata) only
// while the block is idle, unenforced by the block; a value of 0 acts as 1.
module elapsed_time_statistics (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [ets_pkg::WIN_W-1:0]    cfg_wdata,
    // command channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_func,
    input  wire logic [ets_pkg::TICK_W-1:0]   s_tick_value,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [ets_pkg::TICK_W-1:0]        m_run_count,
    output logic [ets_pkg::TICK_W-1:0]        m_mean_time,
    output logic [ets_pkg::TICK_W-1:0]        m_min_time,
    output logic [ets_pkg::TICK_W-1:0]        m_max_time,
    output logic [ets_pkg::TICK_W-1:0]        m_last_time
);
    import ets_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [WIN_W-1:0]  window_reg;
    logic [TICK_W-1:0] start_reg, count_reg, mean_reg, min_reg, max_reg, last_reg;
    logic              m_valid_reg;
    logic [TICK_W-1:0] out_count_reg, out_mean_reg, out_min_reg, out_max_reg, out_last_reg;

    logic              in_xfer;
    logic              out_load;
    logic [TICK_W-1:0] elapsed;
    logic [WIN_W-1:0]  win_eff;
    logic              cumulative;
    ets_req_t          eng_req;
    ets_stat_t         eng_stat;
    logic [TICK_W-1:0] eng_quot;

    assign in_xfer  = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    // output register is free when empty or being emptied this cycle
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // wrap-safe elapsed ticks
    assign elapsed    = s_tick_value - start_reg;
    assign win_eff    = (window_reg == '0) ? {{(WIN_W-1){1'b0}}, 1'b1} : window_reg;
    assign cumulative = (count_reg <= {{(TICK_W-WIN_W){1'b0}}, win_eff});

    // cumulative form uses n-1 and n; prior count is at most the window here
    always_comb begin
        eng_req.mcand  = mean_reg;
        eng_req.addend = elapsed;
        if (cumulative) begin
            eng_req.mult    = count_reg[WIN_W-1:0];
            eng_req.divisor = {1'b0, count_reg[WIN_W-1:0]} + 1'b1;
        end else begin
            eng_req.mult    = win_eff - 1'b1;
            eng_req.divisor = {1'b0, win_eff};
        end
    end

    ets_muldiv u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_xfer && (s_func == FUNC_STOP)),
        .req      (eng_req),
        .stat     (eng_stat),
        .quotient (eng_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = (s_func == FUNC_STOP) ? ST_CALC : ST_DONE;
                end
            end
            ST_CALC: begin
                if (eng_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // statistics registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            window_reg <= WINDOW_RESET;
            start_reg  <= '0;
            count_reg  <= '0;
            mean_reg   <= '0;
            min_reg    <= ALL_ONES;
            max_reg    <= '0;
            last_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            if (in_xfer) begin
                case (s_func)
                    FUNC_CLEAR: begin
                        count_reg <= '0;
                        mean_reg  <= '0;
                        min_reg   <= ALL_ONES;
                        max_reg   <= '0;
                        last_reg  <= '0;
                    end
                    FUNC_START: begin
                        start_reg <= s_tick_value;
                    end
                    FUNC_STOP: begin
                        last_reg <= elapsed;
                        if (count_reg != ALL_ONES) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (elapsed > max_reg) begin
                            max_reg <= elapsed;
                        end
                        if (elapsed < min_reg) begin
                            min_reg <= elapsed;
                        end
                    end
                    default: begin
                        // unused command reports the statistics unchanged
                    end
                endcase
            end
            if (state_reg == ST_CALC && eng_stat.done) begin
                mean_reg <= eng_quot;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_count_reg <= count_reg;
            out_mean_reg  <= mean_reg;
            out_min_reg   <= min_reg;
            out_max_reg   <= max_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_run_count = out_count_reg;
    assign m_mean_time = out_mean_reg;
    assign m_min_time  = out_min_reg;
    assign m_max_time  = out_max_reg;
    assign m_last_time = out_last_reg;

    // checks
    a_ready_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !eng_stat.busy)
        else $error("input ready while divider busy");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.done |-> (state_reg == ST_CALC))
        else $error("divider result outside calc state");

    a_stop_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_func == FUNC_STOP) |=> (count_reg != '0))
        else $error("stop left count at zero");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (min_reg <= last_reg && last_reg <= max_reg))
        else $error("last elapsed outside min/max");

endmodule
`default_nettype wire
